@@ hdl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable priority queue: record layout,
// controller commands, datapath status, result word and controller states.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Queue depth and width of the fill counter (must hold Depth itself)
  localparam int Depth = 16;
  localparam int CntW  = $clog2(Depth + 1);
  localparam int OccW  = 5;

  // Action codes
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // One stored event record, 44 bits
  typedef struct packed {
    logic [7:0]         prio;
    logic [7:0]         sys;
    logic [7:0]         res;
    logic [3:0]         stat;
    logic signed [15:0] amt;
  } rec_t;

  // Command from controller to datapath
  typedef struct packed {
    logic load;      // capture a new result word
    logic push;      // insert the incoming record
    logic pop;       // remove the head record
    logic accepted;  // result flag for this transfer
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
  } status_t;

  // Registered result word
  typedef struct packed {
    logic            accepted;
    rec_t            rec;
    logic [OccW-1:0] occupancy;
    logic            full_res;
  } res_t;

  // Output register state
  typedef enum logic {
    ST_IDLE,
    ST_HOLD
  } state_e;

endpackage

@@ hdl/spq_in_if.sv @@
// ----------------------------------------------------------------------------
// spq_in_if
// Request channel: push or pop with the event record, valid/ready handshake.
// ----------------------------------------------------------------------------
interface spq_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [7:0]         priority_req;
  logic [7:0]         system_id;
  logic [7:0]         resource_id;
  logic [3:0]         status;
  logic signed [15:0] amount;

  modport source (
    output valid, action, priority_req, system_id, resource_id, status, amount,
    input  ready
  );
  modport sink (
    input  valid, action, priority_req, system_id, resource_id, status, amount,
    output ready
  );
endinterface

@@ hdl/spq_out_if.sv @@
// ----------------------------------------------------------------------------
// spq_out_if
// Result channel: outcome flag, popped record and occupancy, valid/ready.
// ----------------------------------------------------------------------------
interface spq_out_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [7:0]         out_priority;
  logic [7:0]         out_system_id;
  logic [7:0]         out_resource_id;
  logic [3:0]         out_status;
  logic signed [15:0] out_amount;
  logic [4:0]         occupancy;
  logic               full_res;

  modport source (
    output valid, accepted, out_priority, out_system_id, out_resource_id,
           out_status, out_amount, occupancy, full_res,
    input  ready
  );
  modport sink (
    input  valid, accepted, out_priority, out_system_id, out_resource_id,
           out_status, out_amount, occupancy, full_res,
    output ready
  );
endinterface

@@ hdl/stable_priority_queue.sv @@
// Throughput: one push or pop per cycle; a new item transfers while the
// previous result waits, as long as the result channel takes it.
// Latency: the result is presented the cycle after the input transfer; one
// comparator per entry picks the insert slot within that cycle.
// Reset: the fill count and the result register state clear; stored records
// are not cleared and are never read until written.
// ----------------------------------------------------------------------------
// stable_priority_queue
// Fixed-depth priority queue of event records, served highest priority
// first and in arrival order among equal priorities.
// ----------------------------------------------------------------------------
module stable_priority_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  spq_in_if.sink     in_i,
  spq_out_if.source  out_o
);

  spq_pkg::cmd_t    cmd;
  spq_pkg::status_t status;
  spq_pkg::rec_t    rec;
  spq_pkg::res_t    res;

  // Gather the incoming record
  always_comb begin
    rec.prio = in_i.priority_req;
    rec.sys  = in_i.system_id;
    rec.res  = in_i.resource_id;
    rec.stat = in_i.status;
    rec.amt  = in_i.amount;
  end

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  spq_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .rec_i    (rec),
    .status_o (status),
    .res_o    (res)
  );

  // Drive the result channel
  assign out_o.accepted        = res.accepted;
  assign out_o.out_priority    = res.rec.prio;
  assign out_o.out_system_id   = res.rec.sys;
  assign out_o.out_resource_id = res.rec.res;
  assign out_o.out_status      = res.rec.stat;
  assign out_o.out_amount      = res.rec.amt;
  assign out_o.occupancy       = res.occupancy;
  assign out_o.full_res        = res.full_res;

endmodule

@@ hdl/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spq_ctrl
// Controller: tracks the result register, grants input transfers and turns
// each transfer into a push, pop or no-op command for the datapath.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_action_i,
  input  logic             out_ready_i,
  input  spq_pkg::status_t status_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output spq_pkg::cmd_t    cmd_o
);

  spq_pkg::state_e state_q, state_d;
  logic            in_fire;

  assign in_fire = in_valid_i & in_ready_o;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state: hold the result until taken, refill on a new transfer
  always_comb begin
    state_d = state_q;
    case (state_q)
      spq_pkg::ST_IDLE: begin
        if (in_fire) state_d = spq_pkg::ST_HOLD;
      end
      spq_pkg::ST_HOLD: begin
        if (out_ready_i && !in_fire) state_d = spq_pkg::ST_IDLE;
      end
      default: state_d = spq_pkg::ST_IDLE;
    endcase
  end

  // Outputs: handshake and datapath command
  always_comb begin
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    case (state_q)
      spq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      spq_pkg::ST_HOLD: begin
        in_ready_o  = out_ready_i;
        out_valid_o = 1'b1;
      end
      default: begin
        in_ready_o  = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd_o.load     = in_fire;
    cmd_o.push     = in_fire && (in_action_i == spq_pkg::ACT_PUSH) && !status_i.full;
    cmd_o.pop      = in_fire && (in_action_i == spq_pkg::ACT_POP) && !status_i.empty;
    cmd_o.accepted = cmd_o.push | cmd_o.pop;
  end

  // Checks
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped while stalled");
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.push && cmd_o.pop))
    else $error("push and pop issued together");
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> out_valid_o)
    else $error("loaded result not presented");

endmodule

@@ hdl/spq_dp.sv @@
// ----------------------------------------------------------------------------
// spq_dp
// Datapath: sorted shift-register array of event records with one priority
// comparator per entry, fill counter and the registered result word.
// ----------------------------------------------------------------------------
module spq_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  spq_pkg::cmd_t    cmd_i,
  input  spq_pkg::rec_t    rec_i,
  output spq_pkg::status_t status_o,
  output spq_pkg::res_t    res_o
);

  spq_pkg::rec_t             entries_q [spq_pkg::Depth];
  spq_pkg::rec_t             entries_d [spq_pkg::Depth];
  logic [spq_pkg::CntW-1:0]  count_q, count_d;
  logic [spq_pkg::Depth-1:0] ge;
  spq_pkg::res_t             res_q, res_d;

  // Per-entry compare: stored and at least as urgent as the new record
  for (genvar i = 0; i < spq_pkg::Depth; i++) begin : g_cmp
    assign ge[i] = (spq_pkg::CntW'(i) < count_q) && (entries_q[i].prio >= rec_i.prio);
  end

  // Next entry: keep, insert, shift down on push, shift up on pop
  for (genvar i = 0; i < spq_pkg::Depth; i++) begin : g_ent
    spq_pkg::rec_t below;
    spq_pkg::rec_t above;
    logic          first_free;
    if (i == 0) begin : g_first
      assign below      = entries_q[0];
      assign first_free = 1'b1;
    end else begin : g_rest
      assign below      = entries_q[i-1];
      assign first_free = ge[i-1];
    end
    if (i == spq_pkg::Depth - 1) begin : g_last
      assign above = entries_q[i];
    end else begin : g_mid
      assign above = entries_q[i+1];
    end

    always_comb begin
      entries_d[i] = entries_q[i];
      if (cmd_i.push) begin
        if (ge[i])           entries_d[i] = entries_q[i];
        else if (first_free) entries_d[i] = rec_i;
        else                 entries_d[i] = below;
      end else if (cmd_i.pop) begin
        entries_d[i] = above;
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.push || cmd_i.pop) entries_q[i] <= entries_d[i];
    end
  end

  // Fill counter
  always_comb begin
    count_d = count_q;
    if (cmd_i.push)     count_d = count_q + spq_pkg::CntW'(1);
    else if (cmd_i.pop) count_d = count_q - spq_pkg::CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == spq_pkg::CntW'(spq_pkg::Depth));

  // Result word: head record on a pop, zero otherwise
  always_comb begin
    res_d.accepted  = cmd_i.accepted;
    res_d.rec       = cmd_i.pop ? entries_q[0] : '0;
    res_d.occupancy = spq_pkg::OccW'(32'(count_d));
    res_d.full_res  = (count_d == spq_pkg::CntW'(spq_pkg::Depth));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) res_q <= res_d;
  end

  assign res_o = res_q;

  // Checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= spq_pkg::CntW'(spq_pkg::Depth))
    else $error("fill count beyond depth");
  a_push_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |=> count_q == $past(count_q) + spq_pkg::CntW'(1))
    else $error("push did not advance count");
  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |=> count_q == $past(count_q) - spq_pkg::CntW'(1))
    else $error("pop did not reduce count");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> !status_o.full)
    else $error("push into full queue");

endmodule

@@ test/stable_priority_queue_tb.sv @@
// ----------------------------------------------------------------------------
// stable_priority_queue_tb
// Self-checking bench for the stable priority queue. A short table of
// directed pushes and pops covers the empty pop, the full push, the field
// extremes and ties. Several hundred random transfers follow, in phases that
// lean towards push or pop so that the queue swings between empty and full.
// Every result is checked field by field against the table where a row gives
// one, else against an in-bench model of the queue. The request side sends in
// bursts and the result side stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module stable_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomItems = 750;
  localparam int StallLimit  = 500;
  localparam int DrainCycles = 8;

  // One directed row; rows with rep above one step the priority and tag
  typedef struct {
    logic          act;
    spq_pkg::rec_t rec;
    int            rep;
    bit            given;
    spq_pkg::res_t res;
  } stim_row_t;

  // Result typed into the table, carried alongside each item sent
  typedef struct {
    bit            given;
    spq_pkg::res_t res;
  } typed_res_t;

  logic clk;
  logic rst_n;

  spq_in_if  req_if ();
  spq_out_if rsp_if ();

  stable_priority_queue u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if.sink),
    .out_o  (rsp_if.source)
  );

  // Queue contents as the block should hold them, in service order
  spq_pkg::rec_t held_rec [spq_pkg::Depth];
  int            held_count;

  stim_row_t     stim_rows [$];
  typed_res_t    typed_res_q [$];
  spq_pkg::res_t pending_res_q [$];

  int mismatches;
  int idle_cycles;
  int burst_left;

  spq_pkg::res_t seen_res;
  spq_pkg::res_t want_res;
  spq_pkg::res_t next_res;
  spq_pkg::rec_t req_rec;
  typed_res_t    hint;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic spq_pkg::rec_t mk_rec(input logic [7:0] p, input logic [7:0] s,
                                           input logic [7:0] r, input logic [3:0] st,
                                           input logic signed [15:0] a);
    spq_pkg::rec_t rec;
    rec.prio = p;
    rec.sys  = s;
    rec.res  = r;
    rec.stat = st;
    rec.amt  = a;
    return rec;
  endfunction

  function automatic spq_pkg::res_t mk_res(input logic acc, input spq_pkg::rec_t rec,
                                           input logic [spq_pkg::OccW-1:0] occ,
                                           input logic full);
    spq_pkg::res_t res;
    res.accepted  = acc;
    res.rec       = rec;
    res.occupancy = occ;
    res.full_res  = full;
    return res;
  endfunction

  // Apply one push or pop to the held queue and return the outcome
  function automatic spq_pkg::res_t apply_queue_op(input logic act, input spq_pkg::rec_t r);
    spq_pkg::res_t o;
    int            pos;
    o = '0;
    if (act == spq_pkg::ACT_PUSH) begin
      if (held_count < spq_pkg::Depth) begin
        // insert behind every entry of equal or higher priority
        pos = 0;
        while (pos < held_count && held_rec[pos].prio >= r.prio) pos++;
        for (int i = held_count; i > pos; i--) held_rec[i] = held_rec[i-1];
        held_rec[pos] = r;
        held_count++;
        o.accepted = 1'b1;
      end
    end else if (held_count > 0) begin
      o.rec = held_rec[0];
      for (int i = 1; i < held_count; i++) held_rec[i-1] = held_rec[i];
      held_count--;
      o.accepted = 1'b1;
    end
    o.occupancy = spq_pkg::OccW'(held_count);
    o.full_res  = (held_count == spq_pkg::Depth);
    return o;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected 'h%0h, got 'h%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic add_row(input logic act, input spq_pkg::rec_t rec, input int rep,
                         input bit given, input spq_pkg::res_t res);
    stim_row_t row;
    row.act   = act;
    row.rec   = rec;
    row.rep   = rep;
    row.given = given;
    row.res   = res;
    stim_rows.push_back(row);
  endtask

  // Present one item, opening a new burst after a random gap when due
  task automatic send_item(input logic act, input spq_pkg::rec_t r, input bit given,
                           input spq_pkg::res_t res);
    int         gap;
    typed_res_t t;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_if.valid        <= 1'b1;
    req_if.action       <= act;
    req_if.priority_req <= r.prio;
    req_if.system_id    <= r.sys;
    req_if.resource_id  <= r.res;
    req_if.status       <= r.stat;
    req_if.amount       <= r.amt;
    t.given = given;
    t.res   = res;
    typed_res_q.push_back(t);
    // hold until the transfer
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Result side: always ready, random stalls, or long periodic stalls
  initial begin
    int mode;
    int mode_left;
    mode_left = 0;
    mode      = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      case (mode)
        0: begin
          rsp_if.ready <= 1'b1;
        end
        1: begin
          rsp_if.ready <= ($urandom_range(0, 9) < 7);
        end
        default: begin
          rsp_if.ready <= (mode_left % 9 < 3);
        end
      endcase
    end
  end

  // Monitor: check each result transfer, predict each request transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;

      if (rsp_if.valid && rsp_if.ready) begin
        seen_res.accepted  = rsp_if.accepted;
        seen_res.rec.prio  = rsp_if.out_priority;
        seen_res.rec.sys   = rsp_if.out_system_id;
        seen_res.rec.res   = rsp_if.out_resource_id;
        seen_res.rec.stat  = rsp_if.out_status;
        seen_res.rec.amt   = rsp_if.out_amount;
        seen_res.occupancy = rsp_if.occupancy;
        seen_res.full_res  = rsp_if.full_res;
        if (pending_res_q.size() == 0) begin
          $display("%0t ns: result expected none, got 'h%0h", $time, seen_res);
          mismatches++;
        end else begin
          want_res = pending_res_q.pop_front();
          check_field("accepted", want_res.accepted, seen_res.accepted);
          check_field("out_priority", want_res.rec.prio, seen_res.rec.prio);
          check_field("out_system_id", want_res.rec.sys, seen_res.rec.sys);
          check_field("out_resource_id", want_res.rec.res, seen_res.rec.res);
          check_field("out_status", want_res.rec.stat, seen_res.rec.stat);
          check_field("out_amount", want_res.rec.amt, seen_res.rec.amt);
          check_field("occupancy", want_res.occupancy, seen_res.occupancy);
          check_field("full_res", want_res.full_res, seen_res.full_res);
        end
      end

      if (req_if.valid && req_if.ready) begin
        req_rec.prio = req_if.priority_req;
        req_rec.sys  = req_if.system_id;
        req_rec.res  = req_if.resource_id;
        req_rec.stat = req_if.status;
        req_rec.amt  = req_if.amount;
        hint     = typed_res_q.pop_front();
        next_res = apply_queue_op(req_if.action, req_rec);
        pending_res_q.push_back(hint.given ? hint.res : next_res);
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  initial begin
    while (idle_cycles < StallLimit) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    spq_pkg::rec_t r;
    spq_pkg::rec_t noise;
    int            push_pct;
    mismatches  = 0;
    idle_cycles = 0;
    burst_left  = 0;
    held_count  = 0;

    rst_n               <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.action       <= spq_pkg::ACT_PUSH;
    req_if.priority_req <= '0;
    req_if.system_id    <= '0;
    req_if.resource_id  <= '0;
    req_if.status       <= '0;
    req_if.amount       <= '0;

    noise = mk_rec(8'hff, 8'hff, 8'hff, 4'hf, 16'sh7fff);

    // empty pop, extremes, ties, then fill and push into the full queue
    add_row(spq_pkg::ACT_POP, noise, 1, 1'b1, mk_res(1'b0, '0, 5'd0, 1'b0));
    add_row(spq_pkg::ACT_PUSH, mk_rec(8'h00, 8'h00, 8'h00, 4'h0, 16'sh8000), 1, 1'b1,
            mk_res(1'b1, '0, 5'd1, 1'b0));
    add_row(spq_pkg::ACT_PUSH, mk_rec(8'hff, 8'hff, 8'hff, 4'hf, 16'sh7fff), 1, 1'b1,
            mk_res(1'b1, '0, 5'd2, 1'b0));
    add_row(spq_pkg::ACT_PUSH, mk_rec(8'h80, 8'h01, 8'h5a, 4'h5, 16'shffff), 1, 1'b0, '0);
    add_row(spq_pkg::ACT_PUSH, mk_rec(8'h80, 8'h02, 8'ha5, 4'ha, 16'sh1234), 1, 1'b0, '0);
    add_row(spq_pkg::ACT_POP, mk_rec(8'h00, 8'h00, 8'h00, 4'h0, 16'sh0000), 1, 1'b1,
            mk_res(1'b1, mk_rec(8'hff, 8'hff, 8'hff, 4'hf, 16'sh7fff), 5'd3, 1'b0));
    add_row(spq_pkg::ACT_POP, noise, 2, 1'b0, '0);
    add_row(spq_pkg::ACT_POP, noise, 1, 1'b1,
            mk_res(1'b1, mk_rec(8'h00, 8'h00, 8'h00, 4'h0, 16'sh8000), 5'd0, 1'b0));
    add_row(spq_pkg::ACT_POP, noise, 1, 1'b1, mk_res(1'b0, '0, 5'd0, 1'b0));
    add_row(spq_pkg::ACT_PUSH, mk_rec(8'h40, 8'h00, 8'h3c, 4'h9, 16'sh0100),
            spq_pkg::Depth, 1'b0, '0);
    add_row(spq_pkg::ACT_PUSH, mk_rec(8'h10, 8'h77, 8'h66, 4'h1, 16'sh4000), 1, 1'b1,
            mk_res(1'b0, '0, 5'd16, 1'b1));
    add_row(spq_pkg::ACT_PUSH, mk_rec(8'hff, 8'h88, 8'h99, 4'hc, 16'shc000), 1, 1'b1,
            mk_res(1'b0, '0, 5'd16, 1'b1));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the table
    foreach (stim_rows[i]) begin
      for (int k = 0; k < stim_rows[i].rep; k++) begin
        r      = stim_rows[i].rec;
        r.prio = r.prio + 8'(k % 4);
        r.sys  = r.sys + 8'(k);
        send_item(stim_rows[i].act, r, stim_rows[i].given, stim_rows[i].res);
      end
    end

    // random part: phases lean towards push or pop to sweep the fill level
    push_pct = 50;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 15;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      // mostly a narrow priority band so that ties are common
      r.prio = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
      r.sys  = 8'($urandom);
      r.res  = 8'($urandom);
      r.stat = 4'($urandom);
      r.amt  = 16'($urandom);
      send_item(($urandom_range(0, 99) < push_pct) ? spq_pkg::ACT_PUSH : spq_pkg::ACT_POP,
                r, 1'b0, '0);
    end
    req_if.valid <= 1'b0;

    // drain the remaining results, then allow for stray ones
    while (pending_res_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
